>>> rtl/core/dhd_pkg.sv
// detection head decode: shared widths, register codes and payload structs
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dhd_pkg;

  // defaults for the top level parameters
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned MaxClassesDef = 255;

  // fixed field widths
  localparam int unsigned ValW    = 32;
  localparam int unsigned ClsW    = 8;
  localparam int unsigned ConfW   = 31;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned ScaleW  = 31;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned CfgIdxW = 3;

  // back end arithmetic widths
  localparam int unsigned DiffW = ValW + 2;
  localparam int unsigned MagW  = ValW + 1;
  localparam int unsigned LoW   = 17;
  localparam int unsigned HiW   = MagW - LoW;
  localparam int unsigned PpLoW = LoW + ScaleW;
  localparam int unsigned PpHiW = HiW + ScaleW;
  localparam int unsigned ProdW = 2 * ValW + 1;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // number of box elements ahead of the class scores
  localparam logic [IdxW-1:0] BoxCount = IdxW'(4);

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLASS_COUNT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCORE_THRESHOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAD_LEFT        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PAD_TOP         = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INVERSE_SCALE   = 3'd4;

  // register reset values
  localparam logic [ClsW-1:0]   ClassCountRst = 8'd80;
  localparam logic [ThrW-1:0]   ThresholdRst  = 17'd16384;
  localparam logic [ValW-1:0]   PadRst        = '0;
  localparam logic [ScaleW-1:0] InvScaleRst   = 31'd65536;

  typedef struct packed {
    logic [ClsW-1:0]   class_count;
    logic [ThrW-1:0]   score_threshold;
    logic [ValW-1:0]   pad_left;
    logic [ValW-1:0]   pad_top;
    logic [ScaleW-1:0] inverse_scale;
  } cfg_t;

  // one kept candidate, handed from front to back
  typedef struct packed {
    logic [ClsW-1:0]  class_id;
    logic [ConfW-1:0] confidence;
    logic [ValW-1:0]  cx;
    logic [ValW-1:0]  cy;
    logic [ValW-1:0]  w;
    logic [ValW-1:0]  h;
  } job_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic            push;
    logic [IdxW-1:0] idx;
  } front_stat_t;

endpackage

>>> rtl/core/dhd_front.sv
// detection head decode front end: element counter, box capture, running argmax
// depends on dhd_pkg; pushes kept candidates into the request queue
`timescale 1ns / 1ps

module dhd_front import dhd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = MaxClassesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ValW-1:0]  value_i,
  input  logic             q_full_i,
  output logic             push_o,
  output job_t             job_o,
  output front_stat_t      stat_o
);

  // largest class count that can take effect
  localparam logic [IdxW-1:0] MaxCnt =
    (MAX_CLASSES > 255) ? IdxW'(255) : IdxW'(MAX_CLASSES);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [ValW-1:0] box_q [4];
  logic [ValW-1:0] best_score_q, best_score_d;
  logic [ClsW-1:0] best_class_q, best_class_d;
  logic            best_valid_q, best_valid_d;

  logic [IdxW-1:0] cnt_eff;
  logic [IdxW-1:0] score_idx;
  logic            is_box;
  logic            is_last;
  logic            better;
  logic [ValW-1:0] fin_score;
  logic [ClsW-1:0] fin_class;
  logic            fin_valid;
  logic            keep;
  logic            accept;

  // effective class count: zero counts as one, clamp to the build limit
  always_comb begin
    cnt_eff = (cfg_i.class_count == '0) ? IdxW'(1) : IdxW'(cfg_i.class_count);
    if (cnt_eff > MaxCnt) begin
      cnt_eff = MaxCnt;
    end
  end

  // classify the element and fold it into the argmax
  always_comb begin
    is_box    = idx_q < BoxCount;
    score_idx = idx_q - BoxCount;
    is_last   = !is_box && ({1'b0, score_idx} + 10'd1 >= {1'b0, cnt_eff});
    better    = $signed(value_i) > $signed(best_score_q);
    fin_score = better ? value_i : best_score_q;
    fin_class = better ? score_idx[ClsW-1:0] : best_class_q;
    fin_valid = better || best_valid_q;
    keep      = fin_valid &&
                ($signed({fin_score[ValW-1], fin_score}) >=
                 $signed({16'b0, cfg_i.score_threshold}));
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && is_last && keep;

  // next state of counter and argmax
  always_comb begin
    idx_d        = idx_q;
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    best_valid_d = best_valid_q;
    if (accept) begin
      if (is_box) begin
        idx_d = idx_q + IdxW'(1);
      end else if (is_last) begin
        idx_d        = '0;
        best_score_d = '0;
        best_class_d = '0;
        best_valid_d = 1'b0;
      end else begin
        idx_d        = idx_q + IdxW'(1);
        best_score_d = fin_score;
        best_class_d = fin_class;
        best_valid_d = fin_valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      best_score_q <= '0;
      best_class_q <= '0;
      best_valid_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
      best_valid_q <= best_valid_d;
    end
  end

  // box capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && is_box) begin
      box_q[idx_q[1:0]] <= value_i;
    end
  end

  // request for the back end
  always_comb begin
    job_o.class_id   = fin_class;
    job_o.confidence = fin_score[ConfW-1:0];
    job_o.cx         = box_q[0];
    job_o.cy         = box_q[1];
    job_o.w          = box_q[2];
    job_o.h          = box_q[3];
  end

  assign stat_o.push = push_o;
  assign stat_o.idx  = idx_q;

endmodule

>>> rtl/core/dhd_fifo.sv
// detection head decode request queue between front and back end
// depends on dhd_pkg; small register queue of job_t requests
`timescale 1ns / 1ps

module dhd_fifo import dhd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output logic       valid_o,
  output job_t       job_o,
  output fifo_stat_t stat_o
);

  job_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, wptr_d;
  logic [QPtrW-1:0]  rptr_q, rptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  assign valid_o      = count_q != '0;
  assign job_o        = mem_q[rptr_q];
  assign stat_o.full  = count_q == QCntW'(QDepth);
  assign stat_o.empty = count_q == '0;
  assign stat_o.count = count_q;

endmodule

>>> rtl/core/dhd_back.sv
// detection head decode back end: letterbox mapping pipeline with output register
// depends on dhd_pkg; pops requests from dhd_fifo
`timescale 1ns / 1ps

module dhd_back import dhd_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ClsW-1:0]   class_id_o,
  output logic [ConfW-1:0]  confidence_o,
  output logic [ValW-1:0]   left_o,
  output logic [ValW-1:0]   top_o,
  output logic [ValW-1:0]   box_width_o,
  output logic [ValW-1:0]   box_height_o,
  output logic [ValW-1:0]   centre_x_o,
  output logic [ValW-1:0]   centre_y_o
);

  localparam logic [ProdW-1:0] RoundBit = ProdW'(1) << (FRAC_BITS - 1);

  // magnitude of a signed difference
  function automatic logic [MagW-1:0] mag_of(input logic [DiffW-1:0] d);
    logic [DiffW-1:0] n;
    n = d[DiffW-1] ? (~d + DiffW'(1)) : d;
    return n[MagW-1:0];
  endfunction

  // apply the sign to the rounded, rescaled magnitude, saturate to 32 bits
  function automatic logic [ValW-1:0] round_sat(input logic [ProdW-1:0] r, input logic neg);
    logic [ValW-1:0] res;
    if (neg) begin
      res = (|r[ProdW-1:ValW-1]) ? {1'b1, {(ValW-1){1'b0}}} : (~r[ValW-1:0] + ValW'(1));
    end else begin
      res = (|r[ProdW-1:ValW-1]) ? {1'b0, {(ValW-1){1'b1}}} : r[ValW-1:0];
    end
    return res;
  endfunction

  // edge plus half extent, saturated
  function automatic logic [ValW-1:0] add_half_sat(input logic [ValW-1:0] a,
                                                   input logic [ValW-1:0] b);
    logic [ValW:0] s;
    s = {a[ValW-1], a} + {{2{b[ValW-1]}}, b[ValW-1:1]};
    if (s[ValW] != s[ValW-1]) begin
      return s[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
    end
    return s[ValW-1:0];
  endfunction

  // pipeline handshake: a stage loads when empty or draining
  logic a_v_q, b_v_q, c_v_q, o_v_q;
  logic a_rdy, b_rdy, c_rdy, o_rdy;

  assign o_rdy     = !o_v_q || out_ready_i;
  assign c_rdy     = !c_v_q || o_rdy;
  assign b_rdy     = !b_v_q || c_rdy;
  assign a_rdy     = !a_v_q || b_rdy;
  assign job_pop_o = job_valid_i && a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= job_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (o_rdy) o_v_q <= c_v_q;
    end
  end

  // stage a: padded differences and their magnitudes
  logic [DiffW-1:0] diff [4];
  logic [MagW-1:0]  a_mag_q [4];
  logic [3:0]       a_neg_q;
  logic [ClsW-1:0]  a_cls_q;
  logic [ConfW-1:0] a_conf_q;

  always_comb begin
    diff[0] = {{2{job_i.cx[ValW-1]}}, job_i.cx}
            - {{3{job_i.w[ValW-1]}}, job_i.w[ValW-1:1]}
            - {{2{cfg_i.pad_left[ValW-1]}}, cfg_i.pad_left};
    diff[1] = {{2{job_i.cy[ValW-1]}}, job_i.cy}
            - {{3{job_i.h[ValW-1]}}, job_i.h[ValW-1:1]}
            - {{2{cfg_i.pad_top[ValW-1]}}, cfg_i.pad_top};
    diff[2] = {{2{job_i.w[ValW-1]}}, job_i.w};
    diff[3] = {{2{job_i.h[ValW-1]}}, job_i.h};
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      for (int i = 0; i < 4; i++) begin
        a_mag_q[i] <= mag_of(diff[i]);
        a_neg_q[i] <= diff[i][DiffW-1];
      end
      a_cls_q  <= job_i.class_id;
      a_conf_q <= job_i.confidence;
    end
  end

  // stage b: two partial products per value
  logic [PpLoW-1:0] b_lo_q [4];
  logic [PpHiW-1:0] b_hi_q [4];
  logic [3:0]       b_neg_q;
  logic [ClsW-1:0]  b_cls_q;
  logic [ConfW-1:0] b_conf_q;

  always_ff @(posedge clk_i) begin
    if (b_rdy) begin
      for (int i = 0; i < 4; i++) begin
        b_lo_q[i] <= PpLoW'(a_mag_q[i][LoW-1:0]) * PpLoW'(cfg_i.inverse_scale);
        b_hi_q[i] <= PpHiW'(a_mag_q[i][MagW-1:LoW]) * PpHiW'(cfg_i.inverse_scale);
      end
      b_neg_q  <= a_neg_q;
      b_cls_q  <= a_cls_q;
      b_conf_q <= a_conf_q;
    end
  end

  // stage c: combine, round, sign and saturate
  logic [ProdW-1:0] prod [4];
  logic [ValW-1:0]  c_val_q [4];
  logic [ClsW-1:0]  c_cls_q;
  logic [ConfW-1:0] c_conf_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = (ProdW'(b_lo_q[i]) + (ProdW'(b_hi_q[i]) << LoW) + RoundBit) >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy) begin
      for (int i = 0; i < 4; i++) begin
        c_val_q[i] <= round_sat(prod[i], b_neg_q[i]);
      end
      c_cls_q  <= b_cls_q;
      c_conf_q <= b_conf_q;
    end
  end

  // output register with the centre sums
  always_ff @(posedge clk_i) begin
    if (o_rdy) begin
      class_id_o   <= c_cls_q;
      confidence_o <= c_conf_q;
      left_o       <= c_val_q[0];
      top_o        <= c_val_q[1];
      box_width_o  <= c_val_q[2];
      box_height_o <= c_val_q[3];
      centre_x_o   <= add_half_sat(c_val_q[0], c_val_q[2]);
      centre_y_o   <= add_half_sat(c_val_q[1], c_val_q[3]);
    end
  end

  assign out_valid_o = o_v_q;

endmodule

>>> rtl/core/detection_head_decode_core.sv
// detection head decode top level: configuration registers, front, queue, back
// depends on dhd_pkg, dhd_front, dhd_fifo and dhd_back
`timescale 1ns / 1ps

// Streaming decoder for a one-stage detector head. Values arrive one per
// cycle as cx, cy, w, h and then class_count scores; the block takes a new
// value every cycle while the two-entry request queue has room, and input
// only stalls when results back up at the output. A kept candidate's result
// passes the queue, the difference stage, the partial-product stage with
// 17x31 and 16x31 multipliers, the round and saturate stage and the output
// register with the centre sums, and results can leave one per cycle while
// the output is ready. The argmax takes the first strictly greater positive
// score; a best score equal to the threshold is kept. Configuration writes
// are registered and must happen with no candidate in flight.
module detection_head_decode_core import dhd_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned MAX_CLASSES = MaxClassesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ValW-1:0]    value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ClsW-1:0]    class_id_o,
  output logic [ConfW-1:0]   confidence_o,
  output logic [ValW-1:0]    left_o,
  output logic [ValW-1:0]    top_o,
  output logic [ValW-1:0]    box_width_o,
  output logic [ValW-1:0]    box_height_o,
  output logic [ValW-1:0]    centre_x_o,
  output logic [ValW-1:0]    centre_y_o
);

  cfg_t        cfg_q, cfg_d;
  logic        push;
  job_t        push_job;
  job_t        head_job;
  logic        head_valid;
  logic        pop;
  fifo_stat_t  fifo_stat;
  front_stat_t front_stat;

  // configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLASS_COUNT:     cfg_d.class_count     = cfg_data_i[ClsW-1:0];
        CFG_SCORE_THRESHOLD: cfg_d.score_threshold = cfg_data_i[ThrW-1:0];
        CFG_PAD_LEFT:        cfg_d.pad_left        = cfg_data_i;
        CFG_PAD_TOP:         cfg_d.pad_top         = cfg_data_i;
        CFG_INVERSE_SCALE:   cfg_d.inverse_scale   = cfg_data_i[ScaleW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_count     <= ClassCountRst;
      cfg_q.score_threshold <= ThresholdRst;
      cfg_q.pad_left        <= PadRst;
      cfg_q.pad_top         <= PadRst;
      cfg_q.inverse_scale   <= InvScaleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: counting and argmax
  dhd_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .q_full_i   (fifo_stat.full),
    .push_o     (push),
    .job_o      (push_job),
    .stat_o     (front_stat)
  );

  // request queue
  dhd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job),
    .stat_o  (fifo_stat)
  );

  // back end: letterbox mapping
  dhd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (head_valid),
    .job_i        (head_job),
    .job_pop_o    (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .class_id_o   (class_id_o),
    .confidence_o (confidence_o),
    .left_o       (left_o),
    .top_o        (top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .centre_x_o   (centre_x_o),
    .centre_y_o   (centre_y_o)
  );

`ifndef ASSERT_OFF
  // a request is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.push |-> !fifo_stat.full)
    else $error("request pushed into full queue");

  // the back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  // the queue fill never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= QCntW'(QDepth))
    else $error("queue fill above depth");

  // the element counter stays within box plus largest class count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.idx <= BoxCount + IdxW'(254))
    else $error("element counter out of range");
`endif

endmodule

>>> bench/tb_detection_head_decode_core.sv
// testbench for detection_head_decode_core: directed table, then randomized
// candidates checked against a local decode predictor; depends on dhd_pkg
`timescale 1ns / 1ps

module tb_detection_head_decode_core;
  import dhd_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned TargetValues = 1300;
  localparam longint      SatHi        = 64'sd2147483647;
  localparam longint      SatLo        = -64'sd2147483648;

  // one detection as it leaves the block
  typedef struct packed {
    logic [ClsW-1:0]  class_id;
    logic [ConfW-1:0] confidence;
    logic [ValW-1:0]  left;
    logic [ValW-1:0]  top;
    logic [ValW-1:0]  box_width;
    logic [ValW-1:0]  box_height;
    logic [ValW-1:0]  centre_x;
    logic [ValW-1:0]  centre_y;
  } det_t;

  typedef enum logic {ROW_VAL, ROW_CFG} row_kind_e;

  // value rows send data reps times; register rows write data to reg_sel
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_sel;
    logic [8:0]         reps;
    logic [ValW-1:0]    data;
    logic               chk;
    det_t               want;
  } step_row_t;

  localparam det_t NoDet = '0;
  // register field is ignored on value rows
  localparam logic [CfgIdxW-1:0] UnusedReg = CFG_CLASS_COUNT;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i    = CFG_CLASS_COUNT;
  logic [ValW-1:0]    cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [ValW-1:0]    value_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [ClsW-1:0]    class_id_o;
  logic [ConfW-1:0]   confidence_o;
  logic [ValW-1:0]    left_o;
  logic [ValW-1:0]    top_o;
  logic [ValW-1:0]    box_width_o;
  logic [ValW-1:0]    box_height_o;
  logic [ValW-1:0]    centre_x_o;
  logic [ValW-1:0]    centre_y_o;

  // predictor copy of the registers and the candidate state
  logic [ClsW-1:0]   dec_cnt   = ClassCountRst;
  logic [ThrW-1:0]   dec_thr   = ThresholdRst;
  longint            dec_pad_x = 0;
  longint            dec_pad_y = 0;
  logic [ScaleW-1:0] dec_inv   = InvScaleRst;
  int unsigned       elem_idx  = 0;
  longint            box_q [4] = '{0, 0, 0, 0};
  longint            top_score = 0;
  int unsigned       top_class = 0;
  bit                top_found = 1'b0;

  det_t pending_dets [$];
  det_t head_det;
  int   items_sent   = 0;
  int   results_seen = 0;
  int   fail_count   = 0;
  bit   idle_on      = 1'b1;
  int   hold_asks    = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;

  // directed stimulus
  step_row_t dir_steps [0:46] = '{
    // reset settings: 80 classes, threshold 0.25, no padding, unit scale
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0064_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0032_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0014_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h000A_0000, 1'b0, NoDet},
    // zero scores never win
    '{ROW_VAL, UnusedReg, 9'd5, 32'h0000_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_8000, 1'b0, NoDet},
    // equal scores keep the first
    '{ROW_VAL, UnusedReg, 9'd73, 32'h0000_8000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_4000, 1'b1,
      '{8'd5, 31'h0000_8000, 32'h005A_0000, 32'h002D_0000,
        32'h0014_0000, 32'h000A_0000, 32'h0064_0000, 32'h0032_0000}},
    // two classes, threshold 1.0, box at the value extremes
    '{ROW_CFG, CFG_CLASS_COUNT, 9'd1, 32'd2, 1'b0, NoDet},
    '{ROW_CFG, CFG_SCORE_THRESHOLD, 9'd1, 32'h0001_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h7FFF_FFFF, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h8000_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h7FFF_FFFF, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h8000_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0001_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h7FFF_FFFF, 1'b1,
      '{8'd1, 31'h7FFF_FFFF, 32'h4000_0000, 32'hC000_0000,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}},
    // best score equal to the threshold is kept
    '{ROW_VAL, UnusedReg, 9'd4, 32'h0000_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0001_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0001_0000, 1'b1,
      '{8'd0, 31'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    // best below the threshold is dropped, negative score never wins
    '{ROW_VAL, UnusedReg, 9'd4, 32'h0000_1234, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_FFFF, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h8000_0000, 1'b0, NoDet},
    // class count zero acts as one, zero threshold
    '{ROW_CFG, CFG_CLASS_COUNT, 9'd1, 32'd0, 1'b0, NoDet},
    '{ROW_CFG, CFG_SCORE_THRESHOLD, 9'd1, 32'd0, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd4, 32'h0010_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd4, 32'h0010_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_0001, 1'b1,
      '{8'd0, 31'h0000_0001, 32'h0008_0000, 32'h0008_0000,
        32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000}},
    // zero inverse scale clears every box output
    '{ROW_CFG, CFG_INVERSE_SCALE, 9'd1, 32'd0, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd4, 32'h0123_4567, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_0100, 1'b1,
      '{8'd0, 31'h0000_0100, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
    // letterbox extremes, odd and negative sizes
    '{ROW_CFG, CFG_PAD_LEFT, 9'd1, 32'h8000_0000, 1'b0, NoDet},
    '{ROW_CFG, CFG_PAD_TOP, 9'd1, 32'h7FFF_FFFF, 1'b0, NoDet},
    '{ROW_CFG, CFG_INVERSE_SCALE, 9'd1, 32'h7FFF_FFFF, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0040_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'hFFC0_0000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_0003, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'hFFFF_FFFD, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_0002, 1'b0, NoDet},
    // class count lowered after three of five scores
    '{ROW_CFG, CFG_CLASS_COUNT, 9'd1, 32'd5, 1'b0, NoDet},
    '{ROW_CFG, CFG_PAD_LEFT, 9'd1, 32'h0000_8000, 1'b0, NoDet},
    '{ROW_CFG, CFG_PAD_TOP, 9'd1, 32'hFFFF_0000, 1'b0, NoDet},
    '{ROW_CFG, CFG_INVERSE_SCALE, 9'd1, 32'h0000_C000, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd4, 32'h0021_8001, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd3, 32'h0000_0200, 1'b0, NoDet},
    '{ROW_CFG, CFG_CLASS_COUNT, 9'd1, 32'd2, 1'b0, NoDet},
    '{ROW_VAL, UnusedReg, 9'd1, 32'h0000_0300, 1'b0, NoDet}
  };

  detection_head_decode_core uut (.*);

  always #6 clk_i = ~clk_i;

  // fixed point helpers
  function automatic longint clamp32(input longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  function automatic longint half_down(input longint a);
    return (a >= 0) ? a / 2 : -((-a + 1) / 2);
  endfunction

  // multiply by the inverse scale, round half away from zero, saturate
  function automatic longint scale_q(input longint a, input logic [ScaleW-1:0] k);
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned rnd;
    longint          s;
    mag  = (a < 0) ? -a : a;
    prod = mag * 64'(k);
    rnd  = (prod + (64'd1 << (FracBitsDef - 1))) >> FracBitsDef;
    s    = longint'(rnd);
    return clamp32((a < 0) ? -s : s);
  endfunction

  function automatic void restart_candidate();
    elem_idx  = 0;
    top_score = 0;
    top_class = 0;
    top_found = 1'b0;
  endfunction

  // append one detection to the tail of the expected list
  function automatic void queue_det(input det_t d);
    pending_dets = {pending_dets, d};
  endfunction

  // advance the decode state by one value; returns 1 when a detection is due
  function automatic bit decode_element(input logic [ValW-1:0] v, output det_t d);
    longint      val;
    longint      lft;
    longint      tp;
    longint      bw;
    longint      bh;
    int unsigned eff;
    int unsigned c;
    d   = '0;
    val = longint'(signed'(v));
    eff = (dec_cnt == 0) ? 1 : dec_cnt;
    if (eff > MaxClassesDef) eff = MaxClassesDef;
    if (elem_idx < 4) begin
      box_q[elem_idx] = val;
      elem_idx++;
      return 1'b0;
    end
    c = elem_idx - 4;
    if (val > top_score) begin
      top_score = val;
      top_class = c;
      top_found = 1'b1;
    end
    if (c + 1 < eff) begin
      elem_idx++;
      return 1'b0;
    end
    if (!top_found || top_score < longint'(dec_thr)) begin
      restart_candidate();
      return 1'b0;
    end
    lft          = scale_q(box_q[0] - half_down(box_q[2]) - dec_pad_x, dec_inv);
    tp           = scale_q(box_q[1] - half_down(box_q[3]) - dec_pad_y, dec_inv);
    bw           = scale_q(box_q[2], dec_inv);
    bh           = scale_q(box_q[3], dec_inv);
    d.class_id   = ClsW'(top_class);
    d.confidence = ConfW'(top_score);
    d.left       = ValW'(lft);
    d.top        = ValW'(tp);
    d.box_width  = ValW'(bw);
    d.box_height = ValW'(bh);
    d.centre_x   = ValW'(clamp32(lft + half_down(bw)));
    d.centre_y   = ValW'(clamp32(tp + half_down(bh)));
    restart_candidate();
    return 1'b1;
  endfunction

  // random content
  function automatic logic [ValW-1:0] pick_box();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0280_0000);
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_score();
    case ($urandom_range(0, 9))
      0: return {1'b1, 31'($urandom())};
      1: return '0;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_pad();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0050_0000);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [ValW-1:0] want,
                                      input logic [ValW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  // offer one value request and wait for it to be taken
  task automatic send_value(input logic [ValW-1:0] v, input logic use_table,
                            input det_t table_det);
    det_t calc;
    bit   kept;
    while (idle_on && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    kept = decode_element(v, calc);
    if (use_table) queue_det(table_det);
    else if (kept) queue_det(calc);
    @(negedge clk_i);
  endtask

  // register write once the block has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValW-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_dets.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CLASS_COUNT:     dec_cnt   = data[ClsW-1:0];
      CFG_SCORE_THRESHOLD: dec_thr   = data[ThrW-1:0];
      CFG_PAD_LEFT:        dec_pad_x = longint'(signed'(data));
      CFG_PAD_TOP:         dec_pad_y = longint'(signed'(data));
      CFG_INVERSE_SCALE:   dec_inv   = data[ScaleW-1:0];
      default: ;
    endcase
  endtask

  // output side: random stalls plus the occasional long hold
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_on && $urandom_range(0, 99) < 14);
    end
  end

  // compare each detection with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_dets.size() == 0) begin
        $error("detection with no prediction waiting: class_id %0d confidence %h",
               class_id_o, confidence_o);
        fail_count++;
      end else begin
        head_det = pending_dets.pop_front();
        check_field("class_id", ValW'(head_det.class_id), ValW'(class_id_o));
        check_field("confidence", ValW'(head_det.confidence), ValW'(confidence_o));
        check_field("left", head_det.left, left_o);
        check_field("top", head_det.top, top_o);
        check_field("box_width", head_det.box_width, box_width_o);
        check_field("box_height", head_det.box_height, box_height_o);
        check_field("centre_x", head_det.centre_x, centre_x_o);
        check_field("centre_y", head_det.centre_y, centre_y_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int                phase;
    int                n_cand;
    int                eff;
    int                k;
    bit                holding;
    bit                noisy;
    logic [ClsW-1:0]   cc;
    logic [ThrW-1:0]   thr;
    logic [ScaleW-1:0] inv;
    phase = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == ROW_CFG) begin
        write_reg(dir_steps[i].reg_sel, dir_steps[i].data);
      end else begin
        for (int r = 0; r < dir_steps[i].reps; r++)
          send_value(dir_steps[i].data, dir_steps[i].chk && (r == dir_steps[i].reps - 1),
                     dir_steps[i].want);
      end
    end

    // random phases, each with fresh settings after a full drain
    while (items_sent < TargetValues) begin
      case ($urandom_range(0, 19))
        0: cc = 8'd255;
        1: cc = '0;
        2: cc = 8'd1;
        default: cc = 8'($urandom_range(1, 8));
      endcase
      if (phase == 1) cc = 8'd255;
      case ($urandom_range(0, 5))
        0: thr = '0;
        1: thr = 17'h1_0000;
        default: thr = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 9))
        0: inv = 31'h7FFF_FFFF;
        1: inv = 31'd1;
        2: inv = '0;
        3: inv = 31'($urandom_range(1, 32'h7FFF_FFFF));
        default: inv = 31'($urandom_range(32'h4000, 32'h2_0000));
      endcase
      // hold phases keep almost every candidate so the output backs up
      holding = (phase % 7 == 3);
      if (holding) begin
        cc  = 8'($urandom_range(1, 2));
        thr = '0;
      end
      idle_on = (phase % 6 != 2);
      write_reg(CFG_CLASS_COUNT, ValW'(cc));
      write_reg(CFG_SCORE_THRESHOLD, ValW'(thr));
      write_reg(CFG_PAD_LEFT, pick_pad());
      write_reg(CFG_PAD_TOP, pick_pad());
      write_reg(CFG_INVERSE_SCALE, ValW'(inv));
      eff    = (cc == 0) ? 1 : cc;
      n_cand = (eff > 64) ? $urandom_range(1, 2) : $urandom_range(6, 24);
      if (holding) hold_asks++;
      for (int n = 0; n < n_cand && items_sent < TargetValues; n++) begin
        noisy = ($urandom_range(0, 9) == 0);
        for (k = 0; k < 4 + eff; k++)
          send_value(noisy ? $urandom() : ((k < 4) ? pick_box() : pick_score()),
                     1'b0, NoDet);
      end
      phase++;
    end

    // drain and settle
    in_valid_i <= 1'b0;
    for (k = 0; k < 5000 && pending_dets.size() != 0; k++) @(negedge clk_i);
    if (pending_dets.size() != 0) begin
      $error("%0d predicted detections never arrived", pending_dets.size());
      fail_count++;
    end
    repeat (20) @(negedge clk_i);

    $display("streamed %0d values over %0d random settings phases plus the directed table",
             items_sent, phase);
    $display("checked %0d detections, with output holds of %0d cycles and drained pauses",
             results_seen, HoldCycles);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dhd_pkg.sv
rtl/core/dhd_front.sv
rtl/core/dhd_fifo.sv
rtl/core/dhd_back.sv
rtl/core/detection_head_decode_core.sv
bench/tb_detection_head_decode_core.sv
